// ===== hdl/rtbf_pkg.sv =====
// Shared types and constants for the record-to-block framer.
`timescale 1ns / 1ps

package rtbf_pkg;

    // Largest block the design is built for (bytes).
    localparam int unsigned MAX_BLOCK_BYTES_DEF = 4194304;
    // Smallest block capacity honored; smaller settings saturate here.
    localparam int unsigned MIN_CAPACITY        = 24;
    // Block capacity after reset, before saturation to the build maximum.
    localparam int unsigned CAP_RESET_RAW       = 64512;
    // Width of the block capacity register as written.
    localparam int unsigned CAP_CFG_W           = 23;
    // Entries in the queue between front and back.
    localparam int unsigned QUEUE_DEPTH         = 2;

    // Header lengths in bytes.
    localparam logic [4:0] HDR_LEN_FULL  = 5'd20;
    localparam logic [4:0] HDR_LEN_SHORT = 5'd12;

    // Header format codes.
    localparam logic FMT_FULL  = 1'b0;
    localparam logic FMT_SHORT = 1'b1;

    // Configuration register indexes.
    localparam logic REG_BLOCK_CAPACITY = 1'b0;
    localparam logic REG_HEADER_FORMAT  = 1'b1;

    // Record phase between input beats.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DATA,
        PH_CONT
    } phase_t;

    // Back-end sequencer state.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_HEAD,
        BK_CONT,
        BK_DATA
    } back_state_t;

    // One classified input beat as it travels through the queue.
    typedef struct packed {
        logic               first;
        logic [7:0]         data_byte;
        logic [31:0]        session_id;
        logic [31:0]        session_time;
        logic signed [31:0] file_index;
        logic [30:0]        stream_id;
        logic [31:0]        record_length;
    } cmd_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       end_of_block;
        logic       record_done;
        logic       last_of_run;
    } beat_t;

    // Queue push side (front to queue).
    typedef struct packed {
        logic push;
        cmd_t cmd;
    } push_t;

    // Queue head (queue to back).
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

endpackage

// ===== hdl/record_to_block_framer_core.sv =====
// Top level of the record-to-block framer: config registers and the front/queue/back chain.
`timescale 1ns / 1ps

//  Channel  | Direction | Handshake             | Payload
//  ---------+-----------+-----------------------+------------------------------------------
//  in       | input     | in_valid / in_ready   | first_byte, session_id, session_time,
//           |           |                       | file_index, stream_id, record_length,
//           |           |                       | data_byte
//  out      | output    | out_valid / out_ready | out_byte, byte_present, end_of_block,
//           |           |                       | record_done, last_of_run
//  cfg      | input     | cfg_valid / cfg_ready | cfg_addr (register index), cfg_data
//
//  Result beats leave one per cycle unless out_ready or a field latch holds them; a plain
//  data byte gives one result beat. A data beat that first needs a close or continuation
//  header gives one result beat per header byte and close; a beat that opens a record first
//  latches its fields (up to 41 result beats), and every beat reaches the output register
//  through the queue.
//  Reset (rst_n low, asynchronous) empties the queue, closes any record and restores
//  capacity 64512 (saturated to the build maximum) and the 20-byte header.
//  The two-entry queue lets the front keep accepting beats, until it fills, while the back
//  stalls on out_ready; cfg_ready is always high.

module record_to_block_framer_core #(
    parameter int unsigned MAX_BLOCK_BYTES = rtbf_pkg::MAX_BLOCK_BYTES_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Input beats
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                first_byte,
    input  logic [31:0]                         session_id,
    input  logic [31:0]                         session_time,
    input  logic signed [31:0]                  file_index,
    input  logic [30:0]                         stream_id,
    input  logic [31:0]                         record_length,
    input  logic [7:0]                          data_byte,
    // Result beats
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          out_byte,
    output logic                                byte_present,
    output logic                                end_of_block,
    output logic                                record_done,
    output logic                                last_of_run,
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_addr,
    input  logic [rtbf_pkg::CAP_CFG_W-1:0]      cfg_data
);
    import rtbf_pkg::*;

    // Fill counter and capacity width: wide enough to hold the largest block.
    localparam int unsigned FILL_W = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int unsigned CAP_RESET = (CAP_RESET_RAW > MAX_BLOCK_BYTES) ?
                                        MAX_BLOCK_BYTES : CAP_RESET_RAW;

    logic [FILL_W-1:0] cap_reg;
    logic [FILL_W-1:0] cap_next;
    logic              fmt_reg;
    logic              fmt_next;
    logic [31:0]       cap_wide;
    logic [FILL_W-1:0] cap_sat;
    logic              cfg_write;

    cmd_t  in_cmd;
    push_t q_push;
    head_t q_head;
    logic  q_full;
    logic  pop;
    beat_t out_beat;

    // Configuration: always ready; saturate capacity once at write time.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cap_wide  = 32'(cfg_data);

    always_comb
    begin
        if (cap_wide < 32'(MIN_CAPACITY))
        begin
            cap_sat = FILL_W'(MIN_CAPACITY);
        end
        else if (cap_wide > 32'(MAX_BLOCK_BYTES))
        begin
            cap_sat = FILL_W'(MAX_BLOCK_BYTES);
        end
        else
        begin
            cap_sat = FILL_W'(cap_wide);
        end
    end

    always_comb
    begin
        cap_next = cap_reg;
        fmt_next = fmt_reg;
        if (cfg_write)
        begin
            case (cfg_addr)
                REG_BLOCK_CAPACITY: cap_next = cap_sat;
                REG_HEADER_FORMAT:  fmt_next = cfg_data[0];
                default:            cap_next = cap_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= FILL_W'(CAP_RESET);
            fmt_reg <= FMT_FULL;
        end
        else
        begin
            cap_reg <= cap_next;
            fmt_reg <= fmt_next;
        end
    end

    // Bundle the input beat for the queue.
    assign in_cmd.first         = first_byte;
    assign in_cmd.data_byte     = data_byte;
    assign in_cmd.session_id    = session_id;
    assign in_cmd.session_time  = session_time;
    assign in_cmd.file_index    = file_index;
    assign in_cmd.stream_id     = stream_id;
    assign in_cmd.record_length = record_length;

    // Front: classify and drop stray bytes.
    rtbf_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_cmd   (in_cmd),
        .q_full   (q_full),
        .q_push   (q_push)
    );

    // Queue: decouple the front from back-end stalls.
    rtbf_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_full (q_full),
        .pop    (pop),
        .q_head (q_head)
    );

    // Back: emit header, close and data beats.
    rtbf_back #(
        .FILL_W (FILL_W)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap_reg),
        .hdr_fmt   (fmt_reg),
        .q_head    (q_head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat)
    );

    assign out_byte     = out_beat.out_byte;
    assign byte_present = out_beat.byte_present;
    assign end_of_block = out_beat.end_of_block;
    assign record_done  = out_beat.record_done;
    assign last_of_run  = out_beat.last_of_run;

endmodule

// ===== hdl/rtbf_front.sv =====
// Front end: accepts input beats, tracks open records and drops stray bytes.
`timescale 1ns / 1ps

module rtbf_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rtbf_pkg::cmd_t  in_cmd,
    input  logic            q_full,
    output rtbf_pkg::push_t q_push
);
    import rtbf_pkg::*;

    logic [31:0] left_reg;
    logic [31:0] left_next;
    logic        accept;
    logic        keep;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    // A byte with no open record causes nothing: drop it here.
    assign keep     = in_cmd.first || (left_reg != 32'd0);

    assign q_push.push = accept && keep;
    assign q_push.cmd  = in_cmd;

    // Every kept beat carries one data byte unless the record is empty.
    always_comb
    begin
        left_next = left_reg;
        if (accept)
        begin
            if (in_cmd.first)
            begin
                left_next = (in_cmd.record_length != 32'd0) ?
                            in_cmd.record_length - 32'd1 : 32'd0;
            end
            else if (left_reg != 32'd0)
            begin
                left_next = left_reg - 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= 32'd0;
        end
        else
        begin
            left_reg <= left_next;
        end
    end

endmodule

// ===== hdl/rtbf_queue.sv =====
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module rtbf_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  rtbf_pkg::push_t q_push,
    output logic            q_full,
    input  logic            pop,
    output rtbf_pkg::head_t q_head
);
    import rtbf_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign q_full       = (count_reg == FULL_CNT);
    assign q_head.valid = (count_reg != '0);
    assign q_head.cmd   = entry_reg[rd_ptr_reg];

    assign do_push = q_push.push && !q_full;
    assign do_pop  = pop && q_head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= q_push.cmd;
        end
    end

endmodule

// ===== hdl/rtbf_back.sv =====
// Back end: sequences header, close and data beats into the output register.
`timescale 1ns / 1ps

module rtbf_back #(
    parameter int unsigned FILL_W = 23
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [FILL_W-1:0] cap,
    input  logic            hdr_fmt,
    input  rtbf_pkg::head_t q_head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output rtbf_pkg::beat_t out_beat
);
    import rtbf_pkg::*;

    typedef struct packed {
        beat_t       beat;
        logic        done;
        back_state_t st_nxt;
        logic [4:0]  hcnt_nxt;
        logic [FILL_W-1:0] fill_nxt;
        logic [31:0] left_nxt;
        phase_t      phase_nxt;
    } decision_t;

    back_state_t       state_reg;
    back_state_t       state_next;
    phase_t            phase_reg;
    logic [4:0]        hcnt_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [31:0]       left_reg;
    logic [7:0]        byte_reg;
    logic [31:0]       sid_reg;
    logic [31:0]       stime_reg;
    logic [31:0]       fidx_reg;
    logic [30:0]       stream_reg;
    logic              out_valid_reg;
    beat_t             out_beat_reg;

    logic              slot_free;
    logic              load;
    logic              take;
    logic              fire;
    back_state_t       cur_st;
    logic [7:0]        cur_byte;
    logic [4:0]        hlen;
    logic              hdr_last;
    logic [FILL_W:0]   fill_inc;
    logic              no_fit;
    logic              full;
    logic [31:0]       left_dec;
    logic [2:0]        widx;
    logic [31:0]       stream_word;
    logic [31:0]       hdr_word;
    logic [7:0]        hdr_byte;
    logic              to_data;
    decision_t         dec;

    assign slot_free = !out_valid_reg || out_ready;
    // A new record first latches its header fields; no beat fires while it does.
    assign load      = (state_reg == BK_IDLE) && q_head.valid && q_head.cmd.first;
    assign take      = (state_reg == BK_IDLE) && q_head.valid && !q_head.cmd.first;
    assign fire      = ((state_reg != BK_IDLE) || take) && slot_free;
    assign pop       = load || (take && slot_free);

    always_comb
    begin
        if (state_reg != BK_IDLE)
        begin
            cur_st = state_reg;
        end
        else if (phase_reg == PH_CONT)
        begin
            cur_st = BK_CONT;
        end
        else
        begin
            cur_st = BK_DATA;
        end
    end

    assign cur_byte = (state_reg != BK_IDLE) ? byte_reg : q_head.cmd.data_byte;
    assign hlen     = (hdr_fmt == FMT_SHORT) ? HDR_LEN_SHORT : HDR_LEN_FULL;
    assign hdr_last = (hcnt_reg == hlen - 5'd1);
    assign fill_inc = {1'b0, fill_reg} + (FILL_W + 1)'(1);
    assign no_fit   = ({1'b0, fill_reg} + (FILL_W + 1)'(hlen)) > {1'b0, cap};
    assign full     = (fill_reg >= cap);
    assign left_dec = left_reg - 32'd1;

    // Header words in order: session id, session time, file index, stream, left.
    assign widx        = hcnt_reg[4:2] + ((hdr_fmt == FMT_SHORT) ? 3'd2 : 3'd0);
    assign stream_word = (cur_st == BK_HEAD) ? {1'b0, stream_reg}
                                             : 32'd0 - {1'b0, stream_reg};

    always_comb
    begin
        case (widx)
            3'd0:    hdr_word = sid_reg;
            3'd1:    hdr_word = stime_reg;
            3'd2:    hdr_word = fidx_reg;
            3'd3:    hdr_word = stream_word;
            3'd4:    hdr_word = left_reg;
            default: hdr_word = 32'd0;
        endcase
    end

    always_comb
    begin
        case (hcnt_reg[1:0])
            2'd0:    hdr_byte = hdr_word[31:24];
            2'd1:    hdr_byte = hdr_word[23:16];
            2'd2:    hdr_byte = hdr_word[15:8];
            default: hdr_byte = hdr_word[7:0];
        endcase
    end

    // Beat decision for the current step.
    always_comb
    begin
        dec           = '0;
        dec.st_nxt    = cur_st;
        dec.hcnt_nxt  = hcnt_reg;
        dec.fill_nxt  = fill_reg;
        dec.left_nxt  = left_reg;
        dec.phase_nxt = phase_reg;
        to_data       = 1'b0;
        case (cur_st)
            BK_HEAD, BK_CONT:
            begin
                if ((hcnt_reg == 5'd0) && no_fit)
                begin
                    // Header does not fit: close the block with no byte.
                    dec.beat.end_of_block = 1'b1;
                    dec.fill_nxt          = '0;
                end
                else
                begin
                    dec.beat.out_byte     = hdr_byte;
                    dec.beat.byte_present = 1'b1;
                    dec.fill_nxt          = fill_inc[FILL_W-1:0];
                    dec.hcnt_nxt          = hcnt_reg + 5'd1;
                    if (hdr_last)
                    begin
                        dec.hcnt_nxt = 5'd0;
                        if (fill_inc >= {1'b0, cap})
                        begin
                            dec.beat.end_of_block = 1'b1;
                            dec.fill_nxt          = '0;
                            dec.st_nxt            = (cur_st == BK_HEAD) ? BK_CONT : BK_DATA;
                            to_data               = (cur_st == BK_CONT);
                        end
                        else
                        begin
                            dec.st_nxt = BK_DATA;
                            to_data    = 1'b1;
                        end
                        if (to_data && (left_reg == 32'd0))
                        begin
                            dec.beat.record_done = 1'b1;
                            dec.beat.last_of_run = 1'b1;
                            dec.done             = 1'b1;
                            dec.phase_nxt        = PH_IDLE;
                        end
                    end
                end
            end
            BK_DATA:
            begin
                if (full)
                begin
                    dec.beat.end_of_block = 1'b1;
                    dec.fill_nxt          = '0;
                    dec.st_nxt            = BK_CONT;
                end
                else
                begin
                    dec.beat.out_byte     = cur_byte;
                    dec.beat.byte_present = 1'b1;
                    dec.beat.last_of_run  = 1'b1;
                    dec.done              = 1'b1;
                    dec.fill_nxt          = fill_inc[FILL_W-1:0];
                    dec.left_nxt          = left_dec;
                    if (left_dec == 32'd0)
                    begin
                        dec.beat.record_done = 1'b1;
                        dec.phase_nxt        = PH_IDLE;
                    end
                    else if (fill_inc >= {1'b0, cap})
                    begin
                        dec.beat.end_of_block = 1'b1;
                        dec.fill_nxt          = '0;
                        dec.phase_nxt         = PH_CONT;
                    end
                    else
                    begin
                        dec.phase_nxt = PH_DATA;
                    end
                end
            end
            default:
            begin
                dec.st_nxt = cur_st;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        if (load)
        begin
            state_next = BK_HEAD;
        end
        else if (fire)
        begin
            state_next = dec.done ? BK_IDLE : dec.st_nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            phase_reg     <= PH_IDLE;
            hcnt_reg      <= 5'd0;
            fill_reg      <= '0;
            left_reg      <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                hcnt_reg <= 5'd0;
                left_reg <= q_head.cmd.record_length;
            end
            else if (fire)
            begin
                hcnt_reg  <= dec.hcnt_nxt;
                fill_reg  <= dec.fill_nxt;
                left_reg  <= dec.left_nxt;
                phase_reg <= dec.phase_nxt;
            end
            if (slot_free)
            begin
                out_valid_reg <= fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sid_reg    <= q_head.cmd.session_id;
            stime_reg  <= q_head.cmd.session_time;
            fidx_reg   <= q_head.cmd.file_index;
            stream_reg <= q_head.cmd.stream_id;
        end
        if (load || (take && slot_free))
        begin
            byte_reg <= q_head.cmd.data_byte;
        end
        if (fire)
        begin
            out_beat_reg <= dec.beat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    a_hcnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_IDLE |-> hcnt_reg == 5'd0)
        else $error("header counter not cleared between beats");

    a_close_beat: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !dec.beat.byte_present |-> dec.beat.end_of_block && !dec.beat.last_of_run)
        else $error("close-only beat malformed");

    a_front_sync: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_IDLE && phase_reg == PH_IDLE && q_head.valid |-> q_head.cmd.first)
        else $error("data byte queued with no open record");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && dec.beat.record_done |=> phase_reg == PH_IDLE)
        else $error("record finished but phase still open");

endmodule
